>>> src/wav_pcm_stream_decoder_core_defines.svh
// Assertion macros used by the checker file of the WAV PCM stream decoder.
`ifndef WAV_PCM_STREAM_DECODER_CORE_DEFINES_SVH
`define WAV_PCM_STREAM_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define WPSD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define WPSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/wpsd_pkg.sv
// Shared types and constants of the WAV PCM stream decoder.
package wpsd_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_PCM     = 16'd1;
    localparam logic [31:0] FMT_MIN_LEN = 32'd16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        KIND_SAMPLE,
        KIND_HEADER,
        KIND_NOT_WAVE,
        KIND_CORRUPT,
        KIND_UNSUPPORTED,
        KIND_TRUNCATED
    } wpsd_kind_t;

    typedef struct packed {
        wpsd_kind_t  kind;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic        fin;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] bits;
    } wpsd_cmd_t;

endpackage

>>> src/wpsd_front.sv
// Front part: RIFF/WAVE header parser and frame collector, one byte per request.
module wpsd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  logic [7:0]          byte_value,
    input  logic                end_of_file,
    output logic                push,
    output wpsd_pkg::wpsd_cmd_t cmd
);
    import wpsd_pkg::*;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_FMT_HDR,
        PH_FMT_BODY,
        PH_DATA_HDR,
        PH_DATA,
        PH_IDLE
    } phase_t;

    localparam logic [31:0] POS_TAG  = 32'd3;
    localparam logic [31:0] POS_LEN  = 32'd7;
    localparam logic [31:0] POS_WAVE = 32'd11;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] fmt_last_reg, fmt_last_next;
    logic [15:0] format_reg, format_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] byte_rate_reg, byte_rate_next;
    logic [15:0] align_reg, align_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] left_reg, left_next;
    logic [16:0] idx_reg, idx_next;
    logic [7:0]  b0_reg, b0_next;
    logic [7:0]  b1_reg, b1_next;
    logic [47:0] prod_reg;

    logic        has_kind;
    wpsd_kind_t  kind;
    logic        fin;
    logic        wide_data;
    logic [16:0] fr_data;
    logic        wide_chk;
    logic [16:0] fr_chk;
    logic [48:0] rate_prod;
    logic        fmt_ok;

    always_comb begin
        word_next      = {byte_value, word_reg[31:8]};
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        fmt_last_next  = fmt_last_reg;
        format_next    = format_reg;
        chan_next      = chan_reg;
        rate_next      = rate_reg;
        byte_rate_next = byte_rate_reg;
        align_next     = align_reg;
        bits_next      = bits_reg;
        left_next      = left_reg;
        idx_next       = idx_reg;
        b0_next        = b0_reg;
        b1_next        = b1_reg;
        has_kind       = 1'b0;
        kind           = KIND_SAMPLE;
        fin            = 1'b0;

        wide_data = (bits_reg[15:3] == 13'd2);
        fr_data   = wide_data ? {chan_reg, 1'b0} : {1'b0, chan_reg};

        case (pos_reg)
            32'd0:   format_next[7:0]     = byte_value;
            32'd1:   format_next[15:8]    = byte_value;
            32'd2:   chan_next[7:0]       = byte_value;
            32'd3:   chan_next[15:8]      = byte_value;
            32'd4:   rate_next[7:0]       = byte_value;
            32'd5:   rate_next[15:8]      = byte_value;
            32'd6:   rate_next[23:16]     = byte_value;
            32'd7:   rate_next[31:24]     = byte_value;
            32'd8:   byte_rate_next[7:0]  = byte_value;
            32'd9:   byte_rate_next[15:8] = byte_value;
            32'd10:  byte_rate_next[23:16] = byte_value;
            32'd11:  byte_rate_next[31:24] = byte_value;
            32'd12:  align_next[7:0]      = byte_value;
            32'd13:  align_next[15:8]     = byte_value;
            32'd14:  bits_next[7:0]       = byte_value;
            32'd15:  bits_next[15:8]      = byte_value;
            default: ;
        endcase
        if (phase_reg != PH_FMT_BODY) begin
            format_next    = format_reg;
            chan_next      = chan_reg;
            rate_next      = rate_reg;
            byte_rate_next = byte_rate_reg;
            align_next     = align_reg;
            bits_next      = bits_reg;
        end

        wide_chk  = (bits_next[15:3] == 13'd2);
        fr_chk    = wide_chk ? {chan_next, 1'b0} : {1'b0, chan_next};
        rate_prod = wide_chk ? {prod_reg, 1'b0} : {1'b0, prod_reg};
        fmt_ok    = (format_next == FMT_PCM) && (chan_next != 16'd0) &&
                    ((bits_next[15:3] == 13'd1) || (bits_next[15:3] == 13'd2)) &&
                    ({1'b0, align_next} == fr_chk) &&
                    ({17'd0, byte_rate_next} == rate_prod);

        case (phase_reg)
            PH_RIFF: begin
                if ((pos_reg == POS_TAG && word_next != TAG_RIFF) ||
                    (pos_reg == POS_WAVE && word_next != TAG_WAVE)) begin
                    has_kind   = 1'b1;
                    kind       = KIND_NOT_WAVE;
                    phase_next = PH_IDLE;
                end else if (pos_reg == POS_WAVE) begin
                    phase_next = PH_FMT_HDR;
                    pos_next   = '0;
                end else begin
                    pos_next = pos_reg + 32'd1;
                end
            end
            PH_FMT_HDR: begin
                if ((pos_reg == POS_TAG && word_next != TAG_FMT) ||
                    (pos_reg == POS_LEN && word_next < FMT_MIN_LEN)) begin
                    has_kind   = 1'b1;
                    kind       = KIND_CORRUPT;
                    phase_next = PH_IDLE;
                end else if (pos_reg == POS_LEN) begin
                    fmt_last_next = word_next - 32'd1;
                    phase_next    = PH_FMT_BODY;
                    pos_next      = '0;
                end else begin
                    pos_next = pos_reg + 32'd1;
                end
            end
            PH_FMT_BODY: begin
                if (pos_reg == fmt_last_reg) begin
                    if (!fmt_ok) begin
                        has_kind   = 1'b1;
                        kind       = KIND_UNSUPPORTED;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_DATA_HDR;
                        pos_next   = '0;
                    end
                end else begin
                    pos_next = pos_reg + 32'd1;
                end
            end
            PH_DATA_HDR: begin
                if (pos_reg == POS_TAG && word_next != TAG_DATA) begin
                    has_kind   = 1'b1;
                    kind       = KIND_CORRUPT;
                    phase_next = PH_IDLE;
                end else if (pos_reg == POS_LEN) begin
                    has_kind   = 1'b1;
                    kind       = KIND_HEADER;
                    left_next  = word_next;
                    idx_next   = '0;
                    phase_next = (word_next != 32'd0) ? PH_DATA : PH_IDLE;
                    pos_next   = '0;
                end else begin
                    pos_next = pos_reg + 32'd1;
                end
            end
            PH_DATA: begin
                if (idx_reg == (wide_data ? 17'd1 : 17'd0)) begin
                    b0_next = byte_value;
                end
                if (idx_reg == (wide_data ? 17'd3 : 17'd1)) begin
                    b1_next = byte_value;
                end
                left_next = left_reg - 32'd1;
                if (({1'b0, idx_reg} + 18'd1) >= {1'b0, fr_data}) begin
                    has_kind = 1'b1;
                    kind     = KIND_SAMPLE;
                    fin      = (left_next < {15'd0, fr_data});
                    idx_next = '0;
                end else begin
                    idx_next = idx_reg + 17'd1;
                end
                if (left_next == 32'd0) begin
                    phase_next = PH_IDLE;
                end
            end
            default: ;
        endcase

        if (end_of_file && !has_kind &&
            (phase_next inside {PH_RIFF, PH_FMT_HDR, PH_FMT_BODY, PH_DATA_HDR})) begin
            has_kind = 1'b1;
            kind     = KIND_TRUNCATED;
        end
    end

    assign push         = in_accept && has_kind;
    assign cmd.kind     = kind;
    assign cmd.byte0    = b0_next;
    assign cmd.byte1    = b1_next;
    assign cmd.fin      = fin;
    assign cmd.channels = chan_reg;
    assign cmd.rate     = rate_reg;
    assign cmd.bits     = bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_accept && end_of_file)) begin
            phase_reg     <= PH_RIFF;
            pos_reg       <= '0;
            word_reg      <= '0;
            fmt_last_reg  <= '0;
            format_reg    <= '0;
            chan_reg      <= '0;
            rate_reg      <= '0;
            byte_rate_reg <= '0;
            align_reg     <= '0;
            bits_reg      <= '0;
            left_reg      <= '0;
            idx_reg       <= '0;
            b0_reg        <= '0;
            b1_reg        <= '0;
        end else if (in_accept) begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            word_reg      <= word_next;
            fmt_last_reg  <= fmt_last_next;
            format_reg    <= format_next;
            chan_reg      <= chan_next;
            rate_reg      <= rate_next;
            byte_rate_reg <= byte_rate_next;
            align_reg     <= align_next;
            bits_reg      <= bits_next;
            left_reg      <= left_next;
            idx_reg       <= idx_next;
            b0_reg        <= b0_next;
            b1_reg        <= b1_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= {32'd0, chan_reg} * {16'd0, rate_reg};
    end

endmodule

>>> src/wpsd_queue.sv
// Short command queue between the parser front and the result back.
module wpsd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  wpsd_pkg::wpsd_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output wpsd_pkg::wpsd_cmd_t pop_cmd,
    output logic                empty
);
    import wpsd_pkg::*;

    wpsd_cmd_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic [QUEUE_AW:0]     count_next;

    assign full    = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> src/wpsd_back.sv
// Back part: sample mixing, field masking and the output register.
module wpsd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  wpsd_pkg::wpsd_cmd_t cmd,
    input  logic                empty,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_result_kind,
    output logic signed [8:0]   m_sample_level,
    output logic [15:0]         m_channel_count,
    output logic [31:0]         m_sample_rate,
    output logic [15:0]         m_sample_bits,
    output logic                m_final_frame
);
    import wpsd_pkg::*;

    logic              valid_reg;
    logic [2:0]        kind_reg;
    logic signed [8:0] level_reg;
    logic [15:0]       chan_reg;
    logic [31:0]       rate_reg;
    logic [15:0]       bits_reg;
    logic              fin_reg;

    logic              take;
    logic              mono;
    logic              wide;
    logic              is_sample;
    logic              has_fmt;
    logic [8:0]        sum_u;
    logic [8:0]        sum_s;
    logic [8:0]        mix;

    assign take = !empty && (!valid_reg || m_ready);
    assign pop  = take;

    always_comb begin
        mono      = (cmd.channels == 16'd1);
        wide      = (cmd.bits[15:3] == 13'd2);
        is_sample = (cmd.kind == KIND_SAMPLE);
        has_fmt   = is_sample || (cmd.kind == KIND_HEADER);
        sum_u     = {1'b0, cmd.byte0} + {1'b0, cmd.byte1};
        sum_s     = {cmd.byte0[7], cmd.byte0} + {cmd.byte1[7], cmd.byte1};
        case ({mono, wide})
            2'b11:   mix = {cmd.byte0, 1'b0};
            2'b10:   mix = {cmd.byte0 ^ 8'h80, 1'b0};
            2'b01:   mix = sum_s;
            default: mix = sum_u ^ 9'h100;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            kind_reg  <= cmd.kind;
            level_reg <= is_sample ? mix : '0;
            chan_reg  <= has_fmt ? cmd.channels : '0;
            rate_reg  <= has_fmt ? cmd.rate : '0;
            bits_reg  <= has_fmt ? cmd.bits : '0;
            fin_reg   <= is_sample && cmd.fin;
        end
    end

    assign m_valid         = valid_reg;
    assign m_result_kind   = kind_reg;
    assign m_sample_level  = level_reg;
    assign m_channel_count = chan_reg;
    assign m_sample_rate   = rate_reg;
    assign m_sample_bits   = bits_reg;
    assign m_final_frame   = fin_reg;

endmodule

>>> src/wav_pcm_stream_decoder_core.sv
// Top level of the WAV PCM stream decoder: front parser, command queue, result back.
// A result is written into the command queue and from there into the output register that drives m_valid.
// Throughput: one byte per cycle while the queue is not full; a four-entry queue absorbs output stalls.
// Format check compares byte rate against a registered channels x rate product.
// Reset (aresetn low, synchronous) clears parser, queue and output valid.
// A byte with end_of_file set returns the parser to its reset state.
module wav_pcm_stream_decoder_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_byte_value,
    input  logic              s_end_of_file,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_result_kind,
    output logic signed [8:0] m_sample_level,
    output logic [15:0]       m_channel_count,
    output logic [31:0]       m_sample_rate,
    output logic [15:0]       m_sample_bits,
    output logic              m_final_frame
);
    import wpsd_pkg::*;

    logic      in_accept;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;
    wpsd_cmd_t front_cmd;
    wpsd_cmd_t back_cmd;

    assign s_ready   = !q_full;
    assign in_accept = s_valid && s_ready;

    wpsd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .byte_value  (s_byte_value),
        .end_of_file (s_end_of_file),
        .push        (q_push),
        .cmd         (front_cmd)
    );

    wpsd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (back_cmd),
        .empty    (q_empty)
    );

    wpsd_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (back_cmd),
        .empty           (q_empty),
        .pop             (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_sample_level  (m_sample_level),
        .m_channel_count (m_channel_count),
        .m_sample_rate   (m_sample_rate),
        .m_sample_bits   (m_sample_bits),
        .m_final_frame   (m_final_frame)
    );

endmodule

>>> src/wpsd_checker.sv
// Port-level assertion checker for the WAV PCM stream decoder, with its bind.
`include "wav_pcm_stream_decoder_core_defines.svh"

module wpsd_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [2:0]        m_result_kind,
    input logic signed [8:0] m_sample_level,
    input logic [15:0]       m_channel_count,
    input logic [31:0]       m_sample_rate,
    input logic [15:0]       m_sample_bits,
    input logic              m_final_frame
);
    import wpsd_pkg::*;

    `WPSD_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_result_kind) && $stable(m_sample_level) && $stable(m_final_frame) && $stable(m_sample_rate), "result changed while stalled")

    `WPSD_ASSERT_IMPLIES(a_non_sample_zero, m_valid && m_result_kind != KIND_SAMPLE, m_sample_level == 9'sd0 && !m_final_frame, "level or final flag set outside a sample")

    `WPSD_ASSERT_IMPLIES(a_error_fields_zero, m_valid && (m_result_kind == KIND_NOT_WAVE || m_result_kind == KIND_CORRUPT || m_result_kind == KIND_UNSUPPORTED || m_result_kind == KIND_TRUNCATED), m_channel_count == 16'd0 && m_sample_rate == 32'd0 && m_sample_bits == 16'd0, "format fields set in an error result")

    `WPSD_ASSERT_IMPLIES(a_sample_format, m_valid && m_result_kind == KIND_SAMPLE, m_channel_count != 16'd0 && (m_sample_bits[15:3] == 13'd1 || m_sample_bits[15:3] == 13'd2), "sample emitted with an unsupported format")

endmodule

bind wav_pcm_stream_decoder_core wpsd_checker u_wpsd_checker (.*);

>>> dv/wav_pcm_stream_decoder_core_test.sv
// Testbench for the WAV PCM stream decoder: directed and random WAV byte streams checked against a predictor.
`timescale 1ns / 1ps

module wav_pcm_stream_decoder_core_test;
    import wpsd_pkg::*;

    typedef enum logic [2:0] {
        ST_TAGS,
        ST_FMT_HEAD,
        ST_FMT_BODY,
        ST_DATA_HEAD,
        ST_DATA,
        ST_DONE
    } parse_state_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } wav_byte_t;

    typedef struct {
        wpsd_kind_t        kind;
        logic signed [8:0] level;
        logic [15:0]       channels;
        logic [31:0]       rate;
        logic [15:0]       bits;
        logic              fin;
    } decoded_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [7:0]        s_byte_value = 8'd0;
    logic              s_end_of_file = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [2:0]        m_result_kind;
    logic signed [8:0] m_sample_level;
    logic [15:0]       m_channel_count;
    logic [31:0]       m_sample_rate;
    logic [15:0]       m_sample_bits;
    logic              m_final_frame;

    wav_byte_t  byte_stream[$];
    logic [7:0] file_bytes[$];
    decoded_t   results_due[$];
    int         errors = 0;

    // predictor state
    parse_state_t parse_state;
    logic [31:0]  hdr_pos;
    logic [31:0]  shift_word;
    logic [31:0]  fmt_len_q;
    logic [15:0]  fmt_code;
    logic [15:0]  chans_q;
    logic [31:0]  rate_q;
    logic [31:0]  byte_rate_q;
    logic [15:0]  align_q;
    logic [15:0]  bits_q;
    logic [31:0]  data_left;
    logic [31:0]  frame_idx;
    logic [7:0]   ch0_byte;
    logic [7:0]   ch1_byte;

    wav_byte_t next_req;
    int        send_gap = 0;
    bit        send_calm = 1'b0;
    int        recv_gap = 0;
    bit        recv_calm = 1'b0;
    int        hold_left = 0;
    int        results_seen = 0;
    bit        backlog_done = 1'b0;

    wav_pcm_stream_decoder_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_value    (s_byte_value),
        .s_end_of_file   (s_end_of_file),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_sample_level  (m_sample_level),
        .m_channel_count (m_channel_count),
        .m_sample_rate   (m_sample_rate),
        .m_sample_bits   (m_sample_bits),
        .m_final_frame   (m_final_frame)
    );

    always #4 aclk = ~aclk;

    task automatic clear_state();
        parse_state = ST_TAGS;
        hdr_pos = '0;
        shift_word = '0;
        fmt_len_q = '0;
        fmt_code = '0;
        chans_q = '0;
        rate_q = '0;
        byte_rate_q = '0;
        align_q = '0;
        bits_q = '0;
        data_left = '0;
        frame_idx = '0;
        ch0_byte = '0;
        ch1_byte = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eof);
        bit          emit;
        wpsd_kind_t  kind;
        int          level;
        logic        fin;
        logic [31:0] frame;
        bit          wide;
        bit          hdr;
        int          s0;
        int          s1;
        int          u0;
        int          u1;
        decoded_t    res;
        emit = 1'b0;
        kind = KIND_SAMPLE;
        level = 0;
        fin = 1'b0;
        shift_word = {b, shift_word[31:8]};
        case (parse_state)
            ST_TAGS: begin
                if ((hdr_pos == 3 && shift_word != TAG_RIFF) ||
                    (hdr_pos == 11 && shift_word != TAG_WAVE)) begin
                    emit = 1'b1;
                    kind = KIND_NOT_WAVE;
                end else begin
                    hdr_pos++;
                    if (hdr_pos == 12) begin
                        parse_state = ST_FMT_HEAD;
                        hdr_pos = '0;
                    end
                end
            end
            ST_FMT_HEAD: begin
                if (hdr_pos == 3 && shift_word != TAG_FMT) begin
                    emit = 1'b1;
                    kind = KIND_CORRUPT;
                end else if (hdr_pos == 7) begin
                    fmt_len_q = shift_word;
                    if (fmt_len_q < FMT_MIN_LEN) begin
                        emit = 1'b1;
                        kind = KIND_CORRUPT;
                    end else begin
                        parse_state = ST_FMT_BODY;
                        hdr_pos = '0;
                    end
                end else begin
                    hdr_pos++;
                end
            end
            ST_FMT_BODY: begin
                if (hdr_pos < 2) fmt_code[8*hdr_pos[0] +: 8] = b;
                else if (hdr_pos < 4) chans_q[8*hdr_pos[0] +: 8] = b;
                else if (hdr_pos < 8) rate_q[8*hdr_pos[1:0] +: 8] = b;
                else if (hdr_pos < 12) byte_rate_q[8*hdr_pos[1:0] +: 8] = b;
                else if (hdr_pos < 14) align_q[8*hdr_pos[0] +: 8] = b;
                else if (hdr_pos < 16) bits_q[8*hdr_pos[0] +: 8] = b;
                if (hdr_pos == fmt_len_q - 1) begin
                    frame = {19'd0, bits_q[15:3]} * {16'd0, chans_q};
                    if (fmt_code != FMT_PCM || chans_q == 0 ||
                        (bits_q[15:3] != 1 && bits_q[15:3] != 2) ||
                        {16'd0, align_q} != frame ||
                        {32'd0, byte_rate_q} != {32'd0, frame} * {32'd0, rate_q}) begin
                        emit = 1'b1;
                        kind = KIND_UNSUPPORTED;
                    end else begin
                        parse_state = ST_DATA_HEAD;
                        hdr_pos = '0;
                    end
                end else begin
                    hdr_pos++;
                end
            end
            ST_DATA_HEAD: begin
                if (hdr_pos == 3 && shift_word != TAG_DATA) begin
                    emit = 1'b1;
                    kind = KIND_CORRUPT;
                end else if (hdr_pos == 7) begin
                    data_left = shift_word;
                    emit = 1'b1;
                    kind = KIND_HEADER;
                    frame_idx = '0;
                    parse_state = (data_left != 0) ? ST_DATA : ST_DONE;
                    hdr_pos = '0;
                end else begin
                    hdr_pos++;
                end
            end
            ST_DATA: begin
                frame = {19'd0, bits_q[15:3]} * {16'd0, chans_q};
                wide = (bits_q[15:3] == 2);
                if (frame_idx == (wide ? 1 : 0)) ch0_byte = b;
                if (frame_idx == (wide ? 3 : 1)) ch1_byte = b;
                data_left--;
                if (frame_idx + 1 >= frame) begin
                    s0 = $signed(ch0_byte);
                    s1 = $signed(ch1_byte);
                    u0 = ch0_byte;
                    u1 = ch1_byte;
                    emit = 1'b1;
                    kind = KIND_SAMPLE;
                    if (chans_q == 1) level = wide ? 2 * s0 : 2 * (u0 - 128);
                    else level = wide ? s0 + s1 : u0 + u1 - 256;
                    fin = (data_left < frame);
                    frame_idx = '0;
                end else begin
                    frame_idx++;
                end
                if (data_left == 0) parse_state = ST_DONE;
            end
            default: ;
        endcase

        if (emit && kind >= KIND_NOT_WAVE) parse_state = ST_DONE;
        if (eof && !emit && parse_state <= ST_DATA_HEAD) begin
            emit = 1'b1;
            kind = KIND_TRUNCATED;
        end
        if (emit) begin
            hdr = (kind == KIND_SAMPLE || kind == KIND_HEADER);
            res.kind = kind;
            res.level = level[8:0];
            res.channels = hdr ? chans_q : 16'd0;
            res.rate = hdr ? rate_q : 32'd0;
            res.bits = hdr ? bits_q : 16'd0;
            res.fin = fin;
            results_due.insert(results_due.size(), res);
        end
        if (eof) clear_state();
    endtask

    task automatic match_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic compare_output();
        decoded_t want;
        if (results_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d",
                     $time, m_result_kind);
            errors++;
            return;
        end
        want = results_due.pop_front();
        match_field("kind", {29'd0, m_result_kind}, {29'd0, want.kind});
        match_field("level", {23'd0, m_sample_level}, {23'd0, want.level});
        match_field("channels", {16'd0, m_channel_count}, {16'd0, want.channels});
        match_field("rate", m_sample_rate, want.rate);
        match_field("bits", {16'd0, m_sample_bits}, {16'd0, want.bits});
        match_field("final", {31'd0, m_final_frame}, {31'd0, want.fin});
    endtask

    function automatic int gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_le(input logic [31:0] v, input int n);
        for (int k = 0; k < n; k++) file_bytes.insert(file_bytes.size(), v[8*k +: 8]);
    endtask

    task automatic build_wav(input logic [31:0] riff_tag, input logic [31:0] wave_tag,
                             input logic [31:0] fmt_tag, input logic [31:0] data_tag,
                             input logic [31:0] fmt_len, input logic [15:0] code,
                             input logic [15:0] chans, input logic [31:0] rate,
                             input logic [31:0] byte_rate, input logic [15:0] align,
                             input logic [15:0] bits, input logic [31:0] data_len);
        add_le(riff_tag, 4);
        add_le($urandom(), 4);
        add_le(wave_tag, 4);
        add_le(fmt_tag, 4);
        add_le(fmt_len, 4);
        add_le({16'd0, code}, 2);
        add_le({16'd0, chans}, 2);
        add_le(rate, 4);
        add_le(byte_rate, 4);
        add_le({16'd0, align}, 2);
        add_le({16'd0, bits}, 2);
        for (int k = 16; k < fmt_len && k < 40; k++) begin
            file_bytes.insert(file_bytes.size(), 8'($urandom_range(0, 255)));
        end
        add_le(data_tag, 4);
        add_le(data_len, 4);
    endtask

    // queue the first cut bytes of the file, end of file on the last one
    task automatic send_file(input int cut);
        wav_byte_t item;
        for (int k = 0; k < cut; k++) begin
            item.value = file_bytes[k];
            item.last = (k == cut - 1);
            byte_stream.insert(byte_stream.size(), item);
        end
        file_bytes.delete();
    endtask

    function automatic logic [7:0] audio_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'h7F;
            2: return 8'h80;
            3: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_file();
        int unsigned pick;
        int unsigned n;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [15:0] code;
        logic [15:0] align;
        logic [31:0] rate;
        logic [31:0] byte_rate;
        logic [31:0] frame;
        logic [31:0] fmt_len;
        logic [31:0] data_len;
        logic [31:0] tags[4];
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            n = $urandom_range(1, 20);
            repeat (n) file_bytes.insert(file_bytes.size(), 8'($urandom_range(0, 255)));
            send_file(n);
            return;
        end

        pick = $urandom_range(0, 99);
        if (pick < 45) chans = 1;
        else if (pick < 85) chans = 2;
        else if (pick < 93) chans = 16'($urandom_range(3, 6));
        else if (pick < 96) chans = 0;
        else chans = 16'($urandom_range(7, 65535));

        pick = $urandom_range(0, 99);
        if (pick < 45) bits = 8;
        else if (pick < 85) bits = 16;
        else if (pick < 90) bits = 16'($urandom_range(9, 15));
        else if (pick < 95) bits = 16'($urandom_range(17, 31));
        else bits = 16'($urandom_range(0, 65535));

        pick = $urandom_range(0, 99);
        if (pick < 80) rate = $urandom_range(1, 200000);
        else if (pick < 90) rate = $urandom();
        else if (pick < 95) rate = 32'h8000_0000;
        else rate = 0;

        frame = {19'd0, bits[15:3]} * {16'd0, chans};
        byte_rate = frame * rate;
        align = frame[15:0];
        code = FMT_PCM;
        if ($urandom_range(0, 99) < 4) code = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 99) < 4) align = align ^ (16'd1 << $urandom_range(0, 15));
        if ($urandom_range(0, 99) < 4) byte_rate = byte_rate ^ (32'd1 << $urandom_range(0, 31));

        pick = $urandom_range(0, 99);
        if (pick < 80) fmt_len = 16;
        else if (pick < 94) fmt_len = $urandom_range(17, 24);
        else if (pick < 97) fmt_len = $urandom_range(0, 15);
        else fmt_len = $urandom() | 32'h100;

        tags[0] = TAG_RIFF;
        tags[1] = TAG_WAVE;
        tags[2] = TAG_FMT;
        tags[3] = TAG_DATA;
        for (int k = 0; k < 4; k++) begin
            if ($urandom_range(0, 99) < 3) tags[k] = tags[k] ^ (32'd1 << $urandom_range(0, 31));
        end

        pick = $urandom_range(0, 99);
        if (pick < 8) data_len = 0;
        else if (pick < 93) data_len = $urandom_range(1, 48);
        else if (pick < 97) data_len = $urandom();
        else data_len = 32'hFFFF_FFFF;

        build_wav(tags[0], tags[1], tags[2], tags[3], fmt_len, code, chans, rate,
                  byte_rate, align, bits, data_len);

        pick = $urandom_range(0, 99);
        if (data_len > 48) n = $urandom_range(0, 30);
        else if (pick < 80) n = data_len;
        else if (pick < 90) n = $urandom_range(0, data_len);
        else n = data_len + $urandom_range(1, 8);
        repeat (n) file_bytes.insert(file_bytes.size(), audio_byte());

        if ($urandom_range(0, 99) < 12) send_file($urandom_range(1, file_bytes.size()));
        else send_file(file_bytes.size());
    endtask

    initial begin
        clear_state();

        // end of file on the very first byte
        file_bytes.insert(file_bytes.size(), 8'h52);
        send_file(1);
        // wrong RIFF tag
        add_le(32'h5846_4952, 4);
        send_file(4);
        // fmt chunk too short
        build_wav(TAG_RIFF, TAG_WAVE, TAG_FMT, TAG_DATA, 15, FMT_PCM, 1, 8000, 8000, 1, 8, 0);
        send_file(20);
        // non-PCM format code
        build_wav(TAG_RIFF, TAG_WAVE, TAG_FMT, TAG_DATA, 16, 16'd3, 1, 8000, 8000, 1, 8, 0);
        send_file(36);
        // 8-bit mono extremes
        build_wav(TAG_RIFF, TAG_WAVE, TAG_FMT, TAG_DATA, 16, FMT_PCM, 1, 8000, 8000, 1, 8, 3);
        file_bytes.insert(file_bytes.size(), 8'h00);
        file_bytes.insert(file_bytes.size(), 8'hFF);
        file_bytes.insert(file_bytes.size(), 8'h80);
        send_file(file_bytes.size());
        // 16-bit stereo extremes
        build_wav(TAG_RIFF, TAG_WAVE, TAG_FMT, TAG_DATA, 16, FMT_PCM, 2, 44100, 176400, 4,
                  16, 8);
        add_le(32'h8000_8000, 4);
        add_le(32'h7FFF_7FFF, 4);
        send_file(file_bytes.size());
        // 8-bit stereo extremes, empty data chunk afterwards
        build_wav(TAG_RIFF, TAG_WAVE, TAG_FMT, TAG_DATA, 16, FMT_PCM, 2, 1, 2, 2, 8, 4);
        add_le(32'hFFFF_0000, 4);
        send_file(file_bytes.size());
        build_wav(TAG_RIFF, TAG_WAVE, TAG_FMT, TAG_DATA, 16, FMT_PCM, 1, 8000, 16000, 2, 16, 0);
        send_file(file_bytes.size());

        while (byte_stream.size() < 1650) random_file();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_stream.size() != 0 || s_valid || results_due.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) decode_byte(s_byte_value, s_end_of_file);
            if (!s_valid || s_ready) begin
                if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (byte_stream.size() > 0) begin
                    next_req = byte_stream.pop_front();
                    s_valid <= 1'b1;
                    s_byte_value <= next_req.value;
                    s_end_of_file <= next_req.last;
                    send_gap = send_calm ? 0 : gap_len();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                compare_output();
                results_seen++;
                recv_gap = recv_calm ? 0 : gap_len();
            end
            if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
            // hold off long enough for the result queue to fill and stall requests
            if (results_seen == 60 && !backlog_done) begin
                backlog_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

endmodule

>>> wav_pcm_stream_decoder_core.f
+incdir+src
src/wpsd_pkg.sv
src/wpsd_front.sv
src/wpsd_queue.sv
src/wpsd_back.sv
src/wav_pcm_stream_decoder_core.sv
src/wpsd_checker.sv
dv/wav_pcm_stream_decoder_core_test.sv
